>>> hw/rtl/kpe_pkg.sv
// shared types and constants for the keypad press event engine
package kpe_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd2;

  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_POP = 1'b1;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_SHORT = 3'd1;
  localparam logic [2:0] KIND_LONG = 3'd2;
  localparam logic [2:0] KIND_REPEAT = 3'd3;
  localparam logic [2:0] KIND_RELEASE = 3'd4;

  // one classified input word passed from front to back
  typedef struct packed {
    logic mode;
    logic [4:0] raw;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // event as kept in the ring
  typedef struct packed {
    logic [2:0] key;
    logic [2:0] kind;
    logic [TIME_W-1:0] time_ms;
  } evt_t;

endpackage

>>> hw/rtl/kpe_front.sv
// input side: takes words and queues them in a short fifo
module kpe_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  kpe_pkg::cmd_t in_cmd,
  output logic q_valid,
  input  logic q_take,
  output kpe_pkg::cmd_t q_cmd
);
  kpe_pkg::cmd_t slot [2];
  logic [1:0] count;
  logic wr_ptr;
  logic rd_ptr;
  logic push;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_take};
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_take |-> q_valid)
    else $error("take from empty fifo");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("fifo overflow");
  assert property (@(posedge clk) disable iff (rst)
    (push && !q_take) |=> (count == $past(count) + 2'd1))
    else $error("fifo count slip");
endmodule

>>> hw/rtl/kpe_back.sv
// execution side: walks the keys one at a time and runs the event ring
module kpe_back #(
  parameter int unsigned NUM_KEYS = 5,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic [15:0] long_press_ms,
  input  logic [15:0] repeat_interval_ms,
  input  logic [1:0] settle_samples,
  input  logic q_valid,
  output logic q_take,
  input  kpe_pkg::cmd_t q_cmd,
  output logic out_valid,
  input  logic out_stall,
  output logic event_valid,
  output logic [2:0] event_key,
  output logic [2:0] event_kind,
  output logic [31:0] event_time,
  output logic [4:0] debounced_levels,
  output logic any_pressed,
  output logic [2:0] first_pressed,
  output logic queue_not_empty
);
  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_KEY = 7'b0000010, S_EV2 = 7'b0000100,
    S_POPRD = 7'b0001000, S_POPWT = 7'b0010000, S_SUM = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t state;
  kpe_pkg::cmd_t cur;
  logic [KW-1:0] key;

  logic [NUM_KEYS-1:0] last_raw, accepted_level, held, long_done, release_owed;
  logic [1:0] stable_count [NUM_KEYS];
  logic [31:0] press_start_time [NUM_KEYS];
  logic [31:0] last_repeat_time [NUM_KEYS];

  kpe_pkg::evt_t mem [QUEUE_DEPTH];
  kpe_pkg::evt_t rd_data;
  logic [PW-1:0] write_pointer, read_pointer;

  // second event owed by the current key (repeat after long, release after short)
  logic pend;
  logic [2:0] pend_kind;

  // per-key next state for the key being visited
  logic raw_i, lr_i, acc_i, held_i, ld_i, ro_i, settled;
  logic [1:0] sc_i, sc_n;
  logic [31:0] lrt_i, ps_i;
  logic fire_long, fire_rep, fire_rep_after, do_short, do_rel;
  logic push0;
  logic [2:0] kind0;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    raw_i = (32'(key) < 32'd5) ? cur.raw[3'(key)] : 1'b0;
    lr_i = last_raw[key];
    acc_i = accepted_level[key];
    held_i = held[key];
    ld_i = long_done[key];
    ro_i = release_owed[key];
    sc_i = stable_count[key];
    lrt_i = last_repeat_time[key];
    ps_i = press_start_time[key];
    if (raw_i == lr_i) sc_n = (sc_i < settle_samples) ? sc_i + 2'd1 : sc_i;
    else sc_n = 2'd0;
    settled = (sc_n >= settle_samples);
    fire_long = settled && held_i && raw_i && !ld_i
      && ((cur.now - ps_i) >= {16'd0, long_press_ms});
    fire_rep = settled && held_i && raw_i && ld_i
      && ((cur.now - lrt_i) >= {16'd0, repeat_interval_ms});
    // after a long press last_repeat = now, so diff is 0
    fire_rep_after = fire_long && (repeat_interval_ms == 16'd0);
    do_short = settled && held_i && !raw_i && !ld_i;
    do_rel = settled && held_i && !raw_i && ro_i;
    push0 = fire_long || fire_rep || do_short || do_rel;
    kind0 = fire_long ? kpe_pkg::KIND_LONG : fire_rep ? kpe_pkg::KIND_REPEAT :
            do_short ? kpe_pkg::KIND_SHORT : kpe_pkg::KIND_RELEASE;
  end

  assign q_take = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  logic do_push;
  logic [2:0] push_kind;
  assign do_push = ((state == S_KEY) && push0) || ((state == S_EV2) && pend);
  assign push_kind = (state == S_KEY) ? kind0 : pend_kind;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[write_pointer] <= '{key: 3'(key), kind: push_kind, time_ms: cur.now};
    end
    rd_data <= mem[read_pointer];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      key <= '0;
      last_raw <= '0;
      accepted_level <= '0;
      held <= '0;
      long_done <= '0;
      release_owed <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        stable_count[k] <= 2'd0;
        press_start_time[k] <= 32'd0;
        last_repeat_time[k] <= 32'd0;
      end
      write_pointer <= '0;
      read_pointer <= '0;
      pend <= 1'b0;
      pend_kind <= kpe_pkg::KIND_NONE;
    end else begin
      if (do_push) begin
        if (nxt(write_pointer) == read_pointer) read_pointer <= nxt(read_pointer);
        write_pointer <= nxt(write_pointer);
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_cmd;
            key <= '0;
            event_valid <= 1'b0;
            event_key <= 3'd0;
            event_kind <= kpe_pkg::KIND_NONE;
            event_time <= 32'd0;
            state <= (q_cmd.mode == kpe_pkg::MODE_SCAN) ? S_KEY : S_POPRD;
          end
        end
        S_KEY: begin
          stable_count[key] <= sc_n;
          if (raw_i != lr_i) last_raw[key] <= raw_i;
          pend <= fire_rep_after || (do_short && ro_i);
          pend_kind <= fire_long ? kpe_pkg::KIND_REPEAT : kpe_pkg::KIND_RELEASE;
          if (settled) begin
            accepted_level[key] <= raw_i;
            if (!acc_i && raw_i) begin
              held[key] <= 1'b1;
              press_start_time[key] <= cur.now;
              long_done[key] <= 1'b0;
              last_repeat_time[key] <= 32'd0;
              release_owed[key] <= 1'b0;
            end else if (held_i && raw_i) begin
              if (fire_long) begin
                long_done[key] <= 1'b1;
                release_owed[key] <= 1'b1;
                last_repeat_time[key] <= cur.now;
              end
              if (fire_rep) last_repeat_time[key] <= cur.now;
            end else if (held_i && !raw_i) begin
              held[key] <= 1'b0;
              press_start_time[key] <= 32'd0;
              long_done[key] <= 1'b0;
              last_repeat_time[key] <= 32'd0;
              release_owed[key] <= 1'b0;
            end
          end
          state <= S_EV2;
        end
        S_EV2: begin
          pend <= 1'b0;
          if (32'(key) == NUM_KEYS - 1) state <= S_SUM;
          else begin
            key <= key + KW'(1);
            state <= S_KEY;
          end
        end
        S_POPRD: state <= S_POPWT;
        S_POPWT: begin
          if (write_pointer != read_pointer) begin
            event_valid <= 1'b1;
            event_key <= rd_data.key;
            event_kind <= rd_data.kind;
            event_time <= rd_data.time_ms;
            read_pointer <= nxt(read_pointer);
          end
          state <= S_SUM;
        end
        S_SUM: state <= S_OUT;
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // level summary, registered as the result is formed
  logic [4:0] lev_c;
  logic [2:0] first_c;
  always_comb begin
    lev_c = '0;
    first_c = 3'd0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (accepted_level[k]) first_c = 3'(k);
      if (k < 5) lev_c[k] = accepted_level[k];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      debounced_levels <= lev_c;
      any_pressed <= |accepted_level;
      first_pressed <= first_c;
      queue_not_empty <= (write_pointer != read_pointer);
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !q_take)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POPWT && write_pointer == read_pointer) |=> !event_valid)
    else $error("event from empty ring");
  assert property (@(posedge clk) disable iff (rst)
    do_push |=> write_pointer != read_pointer)
    else $error("push left ring empty");
endmodule

>>> hw/rtl/keypad_press_event_engine.sv
// top level of the keypad press event engine
// Each input word is a scan tick (mode 0: raw key levels and a millisecond
// time) or a pop (mode 1). A two-entry input fifo decouples the port from a
// sequencer that visits the keys one at a time, in a key state and an event
// state per key, writing events into an event ring memory. A scan or a pop
// holds the sequencer from taking the word from the fifo, through the key walk
// or the registered ring read, the forming of the level summary, to the result
// being offered until the receiver takes it; the input stalls once two words
// wait in the fifo. One result word per input word; the oldest event is dropped
// when the ring is full and one slot always stays empty.
module keypad_press_event_engine #(
  parameter int unsigned NUM_KEYS = 5,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  // configuration write port
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [kpe_pkg::CFG_W-1:0] cfg_data,
  // input words
  input  logic in_valid,
  output logic in_stall,
  input  logic mode,
  input  logic [4:0] key_raw,
  input  logic [31:0] now_ms,
  // result words
  output logic out_valid,
  input  logic out_stall,
  output logic event_valid,
  output logic [2:0] event_key,
  output logic [2:0] event_kind,
  output logic [31:0] event_time,
  output logic [4:0] debounced_levels,
  output logic any_pressed,
  output logic [2:0] first_pressed,
  output logic queue_not_empty
);
  logic [15:0] long_press_ms;
  logic [15:0] repeat_interval_ms;
  logic [1:0] settle_samples;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= 16'd1000;
      repeat_interval_ms <= 16'd200;
      settle_samples <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        kpe_pkg::CFG_LONG_PRESS: long_press_ms <= cfg_data;
        kpe_pkg::CFG_REPEAT: repeat_interval_ms <= cfg_data;
        kpe_pkg::CFG_DEBOUNCE: settle_samples <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  kpe_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;
  assign in_cmd = '{mode: mode, raw: key_raw, now: now_ms};

  kpe_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_cmd,
    .q_valid, .q_take, .q_cmd
  );

  kpe_back #(.NUM_KEYS(NUM_KEYS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst, .long_press_ms, .repeat_interval_ms, .settle_samples,
    .q_valid, .q_take, .q_cmd, .out_valid, .out_stall,
    .event_valid, .event_key, .event_kind, .event_time,
    .debounced_levels, .any_pressed, .first_pressed, .queue_not_empty
  );
endmodule

>>> dv/keypad_press_event_engine_tb.sv
// testbench for the keypad press event engine: scoreboard with a scan and queue predictor
module keypad_press_event_engine_tb;

  // expected result word
  typedef struct packed {
    logic ev_valid;
    logic [2:0] key;
    logic [2:0] kind;
    logic [31:0] etime;
    logic [4:0] levels;
    logic any;
    logic [2:0] first;
    logic not_empty;
  } result_t;

  // key event predictor and expected-word store
  class keypad_scoreboard;
    logic [15:0] long_ms;
    logic [15:0] rep_ms;
    logic [1:0] deb;
    logic last_raw [5];
    logic [1:0] stable [5];
    logic level [5];
    logic held [5];
    logic [31:0] start_t [5];
    logic long_done [5];
    logic [31:0] rep_t [5];
    logic rel_owed [5];
    kpe_pkg::evt_t ring [16];
    logic [3:0] wp, rp;
    result_t pending [$];
    int mismatches;

    function void clear();
      long_ms = 16'd1000;
      rep_ms = 16'd200;
      deb = 2'd2;
      for (int i = 0; i < 5; i++) begin
        last_raw[i] = '0; stable[i] = '0; level[i] = '0; held[i] = '0;
        start_t[i] = '0; long_done[i] = '0; rep_t[i] = '0; rel_owed[i] = '0;
      end
      wp = '0; rp = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        kpe_pkg::CFG_LONG_PRESS: long_ms = val;
        kpe_pkg::CFG_REPEAT: rep_ms = val;
        kpe_pkg::CFG_DEBOUNCE: deb = val[1:0];
        default: ;
      endcase
    endfunction

    function void push(int k, logic [2:0] kind, logic [31:0] t);
      if (4'(wp + 4'd1) == rp) rp = 4'(rp + 4'd1);
      ring[wp] = '{key: 3'(k), kind: kind, time_ms: t};
      wp = 4'(wp + 4'd1);
    endfunction

    function void scan_one(int i, logic r, logic [31:0] t);
      logic was;
      if (r == last_raw[i]) begin
        if (stable[i] < deb) stable[i]++;
      end else begin
        stable[i] = 2'd0;
        last_raw[i] = r;
      end
      if (stable[i] < deb) return;
      was = level[i];
      level[i] = r;
      if (!was && r) begin
        held[i] = 1'b1; start_t[i] = t; long_done[i] = 1'b0; rep_t[i] = '0;
        rel_owed[i] = 1'b0;
      end else if (held[i] && r) begin
        if (!long_done[i] && (t - start_t[i]) >= {16'd0, long_ms}) begin
          push(i, kpe_pkg::KIND_LONG, t);
          long_done[i] = 1'b1; rel_owed[i] = 1'b1; rep_t[i] = t;
        end
        if (long_done[i] && (t - rep_t[i]) >= {16'd0, rep_ms}) begin
          push(i, kpe_pkg::KIND_REPEAT, t);
          rep_t[i] = t;
        end
      end else if (held[i] && !r) begin
        if (!long_done[i]) push(i, kpe_pkg::KIND_SHORT, t);
        if (rel_owed[i]) push(i, kpe_pkg::KIND_RELEASE, t);
        held[i] = 1'b0; start_t[i] = '0; long_done[i] = 1'b0; rep_t[i] = '0;
        rel_owed[i] = 1'b0;
      end
    endfunction

    // note an accepted input word and queue up its expected result
    function void note_input(logic m, logic [4:0] raw, logic [31:0] t);
      result_t e;
      e = '0;
      if (m == kpe_pkg::MODE_SCAN) begin
        for (int i = 0; i < 5; i++) scan_one(i, raw[i], t);
      end else if (wp != rp) begin
        e.ev_valid = 1'b1;
        e.key = ring[rp].key;
        e.kind = ring[rp].kind;
        e.etime = ring[rp].time_ms;
        rp = 4'(rp + 4'd1);
      end
      for (int i = 4; i >= 0; i--) begin
        if (level[i]) begin
          e.levels[i] = 1'b1;
          e.any = 1'b1;
          e.first = 3'(i);
        end
      end
      e.not_empty = (wp != rp);
      pending.push_back(e);
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h got %0h", what, exp_v, act_v);
    endfunction

    // compare a result word against the oldest expectation
    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 32'd0, 32'd1);
        return;
      end
      e = pending.pop_front();
      if (got.ev_valid !== e.ev_valid)
        report("event_valid", 32'(e.ev_valid), 32'(got.ev_valid));
      if (got.key !== e.key) report("event_key", 32'(e.key), 32'(got.key));
      if (got.kind !== e.kind) report("event_kind", 32'(e.kind), 32'(got.kind));
      if (got.etime !== e.etime) report("event_time", e.etime, got.etime);
      if (got.levels !== e.levels)
        report("debounced_levels", 32'(e.levels), 32'(got.levels));
      if (got.any !== e.any) report("any_pressed", 32'(e.any), 32'(got.any));
      if (got.first !== e.first)
        report("first_pressed", 32'(e.first), 32'(got.first));
      if (got.not_empty !== e.not_empty)
        report("queue_not_empty", 32'(e.not_empty), 32'(got.not_empty));
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_stall;
  logic mode;
  logic [4:0] key_raw;
  logic [31:0] now_ms;
  logic out_valid, out_stall;
  logic event_valid;
  logic [2:0] event_key, event_kind;
  logic [31:0] event_time;
  logic [4:0] debounced_levels;
  logic any_pressed;
  logic [2:0] first_pressed;
  logic queue_not_empty;

  keypad_scoreboard board;
  logic [31:0] clock_ms;  // running scan time
  bit hold_off;            // long receiver hold-off requested

  keypad_press_event_engine dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key_raw(key_raw), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_valid(event_valid), .event_key(event_key), .event_kind(event_kind),
    .event_time(event_time), .debounced_levels(debounced_levels),
    .any_pressed(any_pressed), .first_pressed(first_pressed),
    .queue_not_empty(queue_not_empty)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drop valid and scramble the idle payload
  task automatic idle_input();
    in_valid <= 1'b0;
    mode <= 1'($urandom_range(0, 1));
    key_raw <= 5'($urandom_range(0, 31));
    now_ms <= $urandom;
  endtask

  // offer one word and wait for its acceptance; the predictor sees it on the edge
  task automatic send_word(logic m, logic [4:0] raw, logic [31:0] t);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      idle_input();
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key_raw <= raw;
    now_ms <= t;
    do @(posedge clk); while (in_stall);
    board.note_input(m, raw, t);
    @(negedge clk);
  endtask

  task automatic scan_at(logic [4:0] raw, int step_ms);
    clock_ms = clock_ms + step_ms;
    send_word(kpe_pkg::MODE_SCAN, raw, clock_ms);
  endtask

  task automatic pop_word();
    send_word(kpe_pkg::MODE_POP, 5'($urandom_range(0, 31)), $urandom);
  endtask

  // wait until every expected word is back, then let the sequencer settle
  task automatic drain();
    idle_input();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold a key pattern for a number of scans at a given step
  task automatic hold_keys(logic [4:0] raw, int scans, int step_ms);
    for (int s = 0; s < scans; s++) scan_at(raw, step_ms);
  endtask

  // one random phase: press sessions with random content plus noise, time jumps and pops
  task automatic random_phase(int words);
    int n;
    logic [4:0] pat;
    n = 0;
    while (n < words) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // well-formed session: press some keys, hold, release
          pat = 5'($urandom_range(1, 31));
          for (int s = $urandom_range(3, 14); s > 0; s--) begin
            scan_at(pat, $urandom_range(0, 3) == 0 ? $urandom_range(0, 600) : 10);
            n++;
          end
          for (int s = $urandom_range(3, 5); s > 0; s--) begin
            scan_at(5'd0, 10);
            n++;
          end
        end
        5, 6: begin
          // bouncing noise
          scan_at(5'($urandom_range(0, 31)), $urandom_range(0, 20));
          n++;
        end
        7: begin
          // big time jump, wraps the clock at times
          scan_at(5'($urandom_range(0, 31)), $urandom);
          n++;
        end
        default: begin
          for (int s = $urandom_range(1, 6); s > 0; s--) begin
            pop_word();
            n++;
          end
        end
      endcase
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
          out_stall <= 1'b0;
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result('{ev_valid: event_valid, key: event_key, kind: event_kind,
                           etime: event_time, levels: debounced_levels, any: any_pressed,
                           first: first_pressed, not_empty: queue_not_empty});
  end

  // run limit
  initial begin
    #20000000;
    $display("keypad_press_event_engine_tb: done, errors");
    $finish;
  end

  initial begin
    board = new();
    board.clear();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = kpe_pkg::CFG_LONG_PRESS;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = kpe_pkg::MODE_SCAN;
    key_raw = '0;
    now_ms = '0;
    hold_off = 1'b0;
    clock_ms = 32'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: pop of empty queue, short press, long press with repeats at reset values
    pop_word();
    hold_keys(5'b00001, 4, 10);
    hold_keys(5'b00000, 4, 10);
    hold_keys(5'b10000, 3, 10);
    hold_keys(5'b10000, 3, 600);   // long press then repeats
    hold_keys(5'b00000, 3, 10);    // release after long
    pop_word(); pop_word(); pop_word(); pop_word(); pop_word();
    drain();

    // zero debounce, zero long press, zero repeat interval
    write_reg(kpe_pkg::CFG_DEBOUNCE, 16'd0);
    write_reg(kpe_pkg::CFG_LONG_PRESS, 16'd0);
    write_reg(kpe_pkg::CFG_REPEAT, 16'd0);
    hold_keys(5'b11111, 3, 10);    // press, then long with repeat, then repeat; fills the ring
    hold_keys(5'b01010, 1, 10);
    hold_keys(5'b00000, 1, 10);
    // time wraps past the top
    clock_ms = 32'hFFFF_FFF0;
    hold_keys(5'b00100, 3, 10);
    hold_keys(5'b00000, 2, 10);
    drain();

    // extremes: full long press and interval, max debounce
    write_reg(kpe_pkg::CFG_DEBOUNCE, 16'd3);
    write_reg(kpe_pkg::CFG_LONG_PRESS, 16'hFFFF);
    write_reg(kpe_pkg::CFG_REPEAT, 16'hFFFF);
    hold_keys(5'b00110, 5, 10);
    hold_keys(5'b00110, 3, 40000);
    hold_keys(5'b00000, 5, 10);
    for (int k = 0; k < 16; k++) pop_word();
    drain();

    // long receiver hold-off while the sender keeps offering words
    write_reg(kpe_pkg::CFG_DEBOUNCE, 16'd1);
    write_reg(kpe_pkg::CFG_LONG_PRESS, 16'd30);
    write_reg(kpe_pkg::CFG_REPEAT, 16'd10);
    hold_off = 1'b1;
    random_phase(60);
    drain();

    // random phases across several settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(kpe_pkg::CFG_DEBOUNCE, 16'($urandom_range(0, 3)));
      write_reg(kpe_pkg::CFG_LONG_PRESS, ph == 7 ? 16'hFFFF : $urandom_range(0, 3) == 0
                ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 120)));
      write_reg(kpe_pkg::CFG_REPEAT, ph == 6 ? 16'hFFFF : $urandom_range(0, 3) == 0
                ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 60)));
      random_phase(210);
      drain();
    end
    write_reg(kpe_pkg::CFG_DEBOUNCE, 16'd2);
    write_reg(kpe_pkg::CFG_LONG_PRESS, 16'd1000);
    write_reg(kpe_pkg::CFG_REPEAT, 16'd200);
    random_phase(40);

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("keypad_press_event_engine_tb: done, clean");
    end else begin
      $display("keypad_press_event_engine_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> keypad_press_event_engine.f
hw/rtl/kpe_pkg.sv
hw/rtl/kpe_front.sv
hw/rtl/kpe_back.sv
hw/rtl/keypad_press_event_engine.sv
dv/keypad_press_event_engine_tb.sv
